@@ sv/euler_to_rotation_matrix_assert.svh @@
// Assertion macros for the Euler angle to rotation matrix block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2R_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define E2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/e2r_pkg.sv @@
// Shared constants, tables and helper functions of the Euler angle to rotation matrix block.
// No dependencies; every other file of the block but the assertion header imports this package.
package e2r_pkg;

    localparam int CORDIC_STAGES_DEF = 14;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int MAX_STAGES        = 20;

    // Three angles travel side by side through every stage.
    localparam int LANES  = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    localparam int ANGLE_IN_W    = 15;
    localparam int ANGLE_IN_FRAC = 12;
    localparam int ENTRY_W       = 16;
    localparam int ENTRY_FRAC    = 14;
    localparam int ONE_Q14       = 16384;

    // CORDIC vector in Q30, sine and cosine in Q20.
    localparam int XY_W      = 33;
    localparam int XY_FRAC   = 30;
    localparam int TRIG_W    = 22;
    localparam int TRIG_FRAC = 20;

    // Products: Q40 pairs, split pair times Q20 for the triple terms, Q60 sums.
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int SPLIT   = 21;
    localparam int HI_W    = PROD_W - SPLIT + TRIG_W;
    localparam int LO_W    = 2 * TRIG_W;
    localparam int SUM_W   = 68;
    localparam int SUM_FRAC = 3 * TRIG_FRAC;

    localparam int MATRIX_STAGES = 5;

    // Matrix entry order on the result channel.
    localparam int ENTRY_COUNT = 9;
    localparam int E_XX = 0;
    localparam int E_XY = 1;
    localparam int E_XZ = 2;
    localparam int E_YX = 3;
    localparam int E_YY = 4;
    localparam int E_YZ = 5;
    localparam int E_ZX = 6;
    localparam int E_ZY = 7;
    localparam int E_ZZ = 8;

    // Pairwise products; the first four also feed the triple terms.
    localparam int PAIR_COUNT   = 8;
    localparam int TRIPLE_COUNT = 4;
    localparam int P_CZSX = 0;
    localparam int P_CXCZ = 1;
    localparam int P_SXSZ = 2;
    localparam int P_CXSZ = 3;
    localparam int P_CYCZ = 4;
    localparam int P_CYSZ = 5;
    localparam int P_CYSX = 6;
    localparam int P_CXCY = 7;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint ATAN_Q30 [MAX_STAGES] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158, 64'sd67021686,
        64'sd33543515,  64'sd16775850,  64'sd8388437,   64'sd4194282,   64'sd2097149,
        64'sd1048575,   64'sd524287,    64'sd262143,    64'sd131071,    64'sd65535,
        64'sd32767,     64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047
    };

    // Round a Q30 constant half-up to the angle format with afrac fraction bits.
    function automatic longint q30_to_angle(longint c, int afrac);
        return (c + (longint'(1) <<< (XY_FRAC - 1 - afrac))) >>> (XY_FRAC - afrac);
    endfunction

endpackage

@@ sv/e2r_angle_if.sv @@
// Valid/ready channel that carries one item of three Euler angles.
// Depends on e2r_pkg for the field widths.
interface e2r_angle_if;
    import e2r_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_IN_W-1:0] angle_x;
    logic signed [ANGLE_IN_W-1:0] angle_y;
    logic signed [ANGLE_IN_W-1:0] angle_z;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                    output ready);
endinterface

@@ sv/e2r_matrix_if.sv @@
// Valid/ready channel that carries one item of a 3x3 rotation matrix in Q1.14.
// Depends on e2r_pkg for the entry width.
interface e2r_matrix_if;
    import e2r_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ENTRY_W-1:0] r_xx;
    logic signed [ENTRY_W-1:0] r_xy;
    logic signed [ENTRY_W-1:0] r_xz;
    logic signed [ENTRY_W-1:0] r_yx;
    logic signed [ENTRY_W-1:0] r_yy;
    logic signed [ENTRY_W-1:0] r_yz;
    logic signed [ENTRY_W-1:0] r_zx;
    logic signed [ENTRY_W-1:0] r_zy;
    logic signed [ENTRY_W-1:0] r_zz;

    modport source (output valid, output r_xx, output r_xy, output r_xz,
                    output r_yx, output r_yy, output r_yz,
                    output r_zx, output r_zy, output r_zz, input ready);
    modport sink   (input valid, input r_xx, input r_xy, input r_xz,
                    input r_yx, input r_yy, input r_yz,
                    input r_zx, input r_zy, input r_zz, output ready);
endinterface

@@ sv/e2r_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation for the three angle lanes, with its stage register.
// Depends on e2r_pkg for the arctangent table and the vector widths.
module e2r_cordic_cell #(
    parameter int STAGE       = 0,
    parameter int ANGLE_WIDTH = e2r_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic signed [e2r_pkg::XY_W-1:0]     x_up   [e2r_pkg::LANES],
    input  logic signed [e2r_pkg::XY_W-1:0]     y_up   [e2r_pkg::LANES],
    input  logic signed [ANGLE_WIDTH:0]         ang_up [e2r_pkg::LANES],
    input  logic [e2r_pkg::LANES-1:0]           flip_up,
    output logic                                down_valid,
    input  logic                                down_ready,
    output logic signed [e2r_pkg::XY_W-1:0]     x_down   [e2r_pkg::LANES],
    output logic signed [e2r_pkg::XY_W-1:0]     y_down   [e2r_pkg::LANES],
    output logic signed [ANGLE_WIDTH:0]         ang_down [e2r_pkg::LANES],
    output logic [e2r_pkg::LANES-1:0]           flip_down
);
    import e2r_pkg::*;

    localparam int AW    = ANGLE_WIDTH + 1;
    localparam int AFRAC = ANGLE_WIDTH - 3;
    localparam logic signed [AW-1:0] ATAN_STEP = AW'(q30_to_angle(ATAN_Q30[STAGE], AFRAC));

    logic                     valid_reg;
    logic signed [XY_W-1:0]   x_reg    [LANES];
    logic signed [XY_W-1:0]   y_reg    [LANES];
    logic signed [AW-1:0]     ang_reg  [LANES];
    logic [LANES-1:0]         flip_reg;
    logic signed [XY_W-1:0]   x_next   [LANES];
    logic signed [XY_W-1:0]   y_next   [LANES];
    logic signed [AW-1:0]     ang_next [LANES];
    logic signed [XY_W-1:0]   dx       [LANES];
    logic signed [XY_W-1:0]   dy       [LANES];

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dx[l] = y_up[l] >>> STAGE;
            dy[l] = x_up[l] >>> STAGE;
            // Rotate toward zero residual angle.
            if (!ang_up[l][AW-1])
            begin
                x_next[l]   = x_up[l] - dx[l];
                y_next[l]   = y_up[l] + dy[l];
                ang_next[l] = ang_up[l] - ATAN_STEP;
            end
            else
            begin
                x_next[l]   = x_up[l] + dx[l];
                y_next[l]   = y_up[l] - dy[l];
                ang_next[l] = ang_up[l] + ATAN_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            flip_reg <= flip_up;
        end
    end

    assign down_valid = valid_reg;
    assign x_down     = x_reg;
    assign y_down     = y_reg;
    assign ang_down   = ang_reg;
    assign flip_down  = flip_reg;

endmodule

@@ sv/e2r_matrix.sv @@
// Sine/cosine rounding, product pipeline and saturation that build the nine matrix entries.
// Depends on e2r_pkg and drives the e2r_matrix_if result channel.
module e2r_matrix (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  logic signed [e2r_pkg::XY_W-1:0]  x_up [e2r_pkg::LANES],
    input  logic signed [e2r_pkg::XY_W-1:0]  y_up [e2r_pkg::LANES],
    input  logic [e2r_pkg::LANES-1:0]        flip_up,
    e2r_matrix_if.source                     matrix
);
    import e2r_pkg::*;

    localparam int ST_TRIG = 0;
    localparam int ST_PROD = 1;
    localparam int ST_PART = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_OUT  = 4;

    localparam int ENT_SHIFT = SUM_FRAC - ENTRY_FRAC;
    localparam logic signed [XY_W-1:0]  XY_HALF    = XY_W'(1) <<< (XY_FRAC - TRIG_FRAC - 1);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (ENT_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(ONE_Q14);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI;
    localparam logic signed [ENTRY_W-1:0] ENT_HI   = ENTRY_W'(ONE_Q14);
    localparam logic signed [ENTRY_W-1:0] ENT_LO   = -ENT_HI;

    logic [MATRIX_STAGES-1:0] stage_valid_reg;
    logic [MATRIX_STAGES-1:0] stage_ready;
    logic [MATRIX_STAGES-1:0] stage_in_valid;
    logic [MATRIX_STAGES-1:0] stage_load;

    logic signed [TRIG_W-1:0]  sin_reg  [LANES];
    logic signed [TRIG_W-1:0]  cos_reg  [LANES];
    logic signed [TRIG_W-1:0]  sin_next [LANES];
    logic signed [TRIG_W-1:0]  cos_next [LANES];
    logic signed [XY_W-1:0]    sin_rnd  [LANES];
    logic signed [XY_W-1:0]    cos_rnd  [LANES];

    logic signed [PROD_W-1:0]  pp_reg   [PAIR_COUNT];
    logic signed [PROD_W-1:0]  pp_next  [PAIR_COUNT];
    logic signed [TRIG_W-1:0]  sy2_reg;

    logic signed [HI_W-1:0]    hi_reg   [TRIPLE_COUNT];
    logic signed [LO_W-1:0]    lo_reg   [TRIPLE_COUNT];
    logic signed [HI_W-1:0]    hi_next  [TRIPLE_COUNT];
    logic signed [LO_W-1:0]    lo_next  [TRIPLE_COUNT];
    logic signed [PROD_W-1:0]  pp3_reg  [PAIR_COUNT];
    logic signed [TRIG_W-1:0]  sy3_reg;

    logic signed [SUM_W-1:0]   triple   [TRIPLE_COUNT];
    logic signed [SUM_W-1:0]   pair     [PAIR_COUNT];
    logic signed [SUM_W-1:0]   ent_reg  [ENTRY_COUNT];
    logic signed [SUM_W-1:0]   ent_next [ENTRY_COUNT];

    logic signed [SUM_W-1:0]   rnd      [ENTRY_COUNT];
    logic signed [ENTRY_W-1:0] mat_reg  [ENTRY_COUNT];
    logic signed [ENTRY_W-1:0] mat_next [ENTRY_COUNT];

    // A stage takes a new item when it is empty or its content moves on this cycle.
    always_comb
    begin
        stage_ready[ST_OUT] = !stage_valid_reg[ST_OUT] || matrix.ready;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k + 1];
        end
    end

    assign stage_in_valid = {stage_valid_reg[MATRIX_STAGES-2:0], up_valid};
    assign stage_load     = stage_ready & stage_in_valid;
    assign up_ready       = stage_ready[ST_TRIG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < MATRIX_STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    stage_valid_reg[k] <= stage_in_valid[k];
                end
            end
        end
    end

    // Round Q30 to Q20; a folded angle flips both sine and cosine.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sin_rnd[l] = (y_up[l] + XY_HALF) >>> (XY_FRAC - TRIG_FRAC);
            cos_rnd[l] = (x_up[l] + XY_HALF) >>> (XY_FRAC - TRIG_FRAC);
            if (flip_up[l])
            begin
                sin_next[l] = -sin_rnd[l][TRIG_W-1:0];
                cos_next[l] = -cos_rnd[l][TRIG_W-1:0];
            end
            else
            begin
                sin_next[l] = sin_rnd[l][TRIG_W-1:0];
                cos_next[l] = cos_rnd[l][TRIG_W-1:0];
            end
        end
    end

    always_comb
    begin
        pp_next[P_CZSX] = cos_reg[LANE_Z] * sin_reg[LANE_X];
        pp_next[P_CXCZ] = cos_reg[LANE_X] * cos_reg[LANE_Z];
        pp_next[P_SXSZ] = sin_reg[LANE_X] * sin_reg[LANE_Z];
        pp_next[P_CXSZ] = cos_reg[LANE_X] * sin_reg[LANE_Z];
        pp_next[P_CYCZ] = cos_reg[LANE_Y] * cos_reg[LANE_Z];
        pp_next[P_CYSZ] = cos_reg[LANE_Y] * sin_reg[LANE_Z];
        pp_next[P_CYSX] = cos_reg[LANE_Y] * sin_reg[LANE_X];
        pp_next[P_CXCY] = cos_reg[LANE_X] * cos_reg[LANE_Y];
    end

    // Each triple product is a pair times sin_y, split into two narrow multiplies.
    always_comb
    begin
        for (int k = 0; k < TRIPLE_COUNT; k++)
        begin
            hi_next[k] = $signed(pp_reg[k][PROD_W-1:SPLIT]) * sy2_reg;
            lo_next[k] = $signed({1'b0, pp_reg[k][SPLIT-1:0]}) * sy2_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < TRIPLE_COUNT; k++)
        begin
            triple[k] = (SUM_W'(hi_reg[k]) <<< SPLIT) + SUM_W'(lo_reg[k]);
        end
        for (int k = 0; k < PAIR_COUNT; k++)
        begin
            pair[k] = SUM_W'(pp3_reg[k]) <<< TRIG_FRAC;
        end
        ent_next[E_XX] = pair[P_CYCZ];
        ent_next[E_XY] = triple[P_CZSX] - pair[P_CXSZ];
        ent_next[E_XZ] = pair[P_SXSZ] + triple[P_CXCZ];
        ent_next[E_YX] = pair[P_CYSZ];
        ent_next[E_YY] = triple[P_SXSZ] + pair[P_CXCZ];
        ent_next[E_YZ] = triple[P_CXSZ] - pair[P_CZSX];
        ent_next[E_ZX] = -(SUM_W'(sy3_reg) <<< (2 * TRIG_FRAC));
        ent_next[E_ZY] = pair[P_CYSX];
        ent_next[E_ZZ] = pair[P_CXCY];
    end

    // Round Q60 half-up to Q14 and clamp to plus or minus one.
    always_comb
    begin
        for (int e = 0; e < ENTRY_COUNT; e++)
        begin
            rnd[e] = (ent_reg[e] + ROUND_HALF) >>> ENT_SHIFT;
            if (rnd[e] > SAT_HI)
            begin
                mat_next[e] = ENT_HI;
            end
            else if (rnd[e] < SAT_LO)
            begin
                mat_next[e] = ENT_LO;
            end
            else
            begin
                mat_next[e] = rnd[e][ENTRY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[ST_TRIG])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
        if (stage_load[ST_PROD])
        begin
            pp_reg  <= pp_next;
            sy2_reg <= sin_reg[LANE_Y];
        end
        if (stage_load[ST_PART])
        begin
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
            pp3_reg <= pp_reg;
            sy3_reg <= sy2_reg;
        end
        if (stage_load[ST_SUM])
        begin
            ent_reg <= ent_next;
        end
        if (stage_load[ST_OUT])
        begin
            mat_reg <= mat_next;
        end
    end

    assign matrix.valid = stage_valid_reg[ST_OUT];
    assign matrix.r_xx  = mat_reg[E_XX];
    assign matrix.r_xy  = mat_reg[E_XY];
    assign matrix.r_xz  = mat_reg[E_XZ];
    assign matrix.r_yx  = mat_reg[E_YX];
    assign matrix.r_yy  = mat_reg[E_YY];
    assign matrix.r_yz  = mat_reg[E_YZ];
    assign matrix.r_zx  = mat_reg[E_ZX];
    assign matrix.r_zy  = mat_reg[E_ZY];
    assign matrix.r_zz  = mat_reg[E_ZZ];

endmodule

@@ sv/euler_to_rotation_matrix.sv @@
// Top level of the Euler angle (roll, pitch, yaw) to rotation matrix block, R = Rz * Ry * Rx.
// Depends on e2r_pkg, e2r_angle_if, e2r_matrix_if, e2r_cordic_cell and e2r_matrix.
//
// Usage: an item on the angles channel carries angle_x, angle_y and angle_z in signed Q2.12
// radians. Each accepted item yields exactly one item on the matrix channel with the nine
// entries in signed Q1.14, clamped to plus or minus 1.0. Items leave in the order they came.
// From acceptance to matrix.valid an item passes one register of angle folding,
// one CORDIC cell per stage for all three angles in parallel, then the matrix registers
// of rounding, two multiply levels, summation and saturation.
// Throughput is one item per cycle while matrix.ready is high; every stage is a register with
// its own valid bit. When the receiver holds matrix.ready low, items keep entering until the
// stages ahead of the stalled result are full, and only then does angles.ready drop.
// Reset empties all stages; the block keeps nothing between items and holds no settings.
`include "euler_to_rotation_matrix_assert.svh"

module euler_to_rotation_matrix #(
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_WIDTH   = e2r_pkg::ANGLE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    e2r_angle_if.sink    angles,
    e2r_matrix_if.source matrix
);
    import e2r_pkg::*;

    localparam int AW       = ANGLE_WIDTH + 1;
    localparam int AFRAC    = ANGLE_WIDTH - 3;
    localparam int SHIFT_UP = (AFRAC >= ANGLE_IN_FRAC) ? AFRAC - ANGLE_IN_FRAC : 0;
    localparam int SHIFT_DN = (AFRAC >= ANGLE_IN_FRAC) ? 0 : ANGLE_IN_FRAC - AFRAC;
    localparam int WIDE_W   = AW + ANGLE_IN_W;
    localparam logic signed [AW-1:0]   HALF_PI_ANG = AW'(q30_to_angle(HALF_PI_Q30, AFRAC));
    localparam logic signed [AW-1:0]   PI_ANG      = AW'(q30_to_angle(PI_Q30, AFRAC));
    localparam logic signed [XY_W-1:0] X_START     = XY_W'(GAIN_Q30);
    localparam logic signed [ENTRY_W-1:0] ENT_HI   = ENTRY_W'(ONE_Q14);
    localparam logic signed [ENTRY_W-1:0] ENT_LO   = -ENT_HI;

    logic signed [ANGLE_IN_W-1:0] angle_in [LANES];
    logic signed [WIDE_W-1:0]     wide     [LANES];
    logic signed [AW-1:0]         scaled   [LANES];
    logic signed [AW-1:0]         ang_next [LANES];
    logic [LANES-1:0]             flip_next;

    logic                         prep_valid_reg;
    logic signed [AW-1:0]         ang_reg  [LANES];
    logic [LANES-1:0]             flip_reg;

    logic [CORDIC_STAGES:0]       chain_valid;
    logic [CORDIC_STAGES:0]       chain_ready;
    logic signed [XY_W-1:0]       chain_x    [CORDIC_STAGES+1][LANES];
    logic signed [XY_W-1:0]       chain_y    [CORDIC_STAGES+1][LANES];
    logic signed [AW-1:0]         chain_ang  [CORDIC_STAGES+1][LANES];
    logic [LANES-1:0]             chain_flip [CORDIC_STAGES+1];

    assign angle_in[LANE_X] = angles.angle_x;
    assign angle_in[LANE_Y] = angles.angle_y;
    assign angle_in[LANE_Z] = angles.angle_z;

    // Bring the angle to the internal format, then fold it into minus pi/2 .. pi/2.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            wide[l]   = (WIDE_W'(angle_in[l]) <<< SHIFT_UP) >>> SHIFT_DN;
            scaled[l] = wide[l][AW-1:0];
            if (scaled[l] > HALF_PI_ANG)
            begin
                ang_next[l]  = scaled[l] - PI_ANG;
                flip_next[l] = 1'b1;
            end
            else if (scaled[l] < -HALF_PI_ANG)
            begin
                ang_next[l]  = scaled[l] + PI_ANG;
                flip_next[l] = 1'b1;
            end
            else
            begin
                ang_next[l]  = scaled[l];
                flip_next[l] = 1'b0;
            end
        end
    end

    assign angles.ready = !prep_valid_reg || chain_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (angles.ready)
        begin
            prep_valid_reg <= angles.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (angles.ready && angles.valid)
        begin
            ang_reg  <= ang_next;
            flip_reg <= flip_next;
        end
    end

    // Head of the CORDIC chain: the vector starts at (gain, 0).
    assign chain_valid[0] = prep_valid_reg;
    assign chain_ang[0]   = ang_reg;
    assign chain_flip[0]  = flip_reg;
    assign chain_x[0]     = '{default: X_START};
    assign chain_y[0]     = '{default: '0};

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cell
        e2r_cordic_cell #(
            .STAGE       (k),
            .ANGLE_WIDTH (ANGLE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[k]),
            .up_ready   (chain_ready[k]),
            .x_up       (chain_x[k]),
            .y_up       (chain_y[k]),
            .ang_up     (chain_ang[k]),
            .flip_up    (chain_flip[k]),
            .down_valid (chain_valid[k+1]),
            .down_ready (chain_ready[k+1]),
            .x_down     (chain_x[k+1]),
            .y_down     (chain_y[k+1]),
            .ang_down   (chain_ang[k+1]),
            .flip_down  (chain_flip[k+1])
        );
    end

    e2r_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[CORDIC_STAGES]),
        .up_ready (chain_ready[CORDIC_STAGES]),
        .x_up     (chain_x[CORDIC_STAGES]),
        .y_up     (chain_y[CORDIC_STAGES]),
        .flip_up  (chain_flip[CORDIC_STAGES]),
        .matrix   (matrix)
    );

    // An accepted item always occupies the folding stage in the next cycle.
    `E2R_ASSERT_NEXT(a_accept_fills_prep, angles.valid && angles.ready, prep_valid_reg,
        "accepted item did not reach the folding stage")

    // With every CORDIC stage full and the matrix pipeline blocked, nothing may enter.
    `E2R_ASSERT_NOW(a_full_chain_blocks, (&chain_valid) && !chain_ready[CORDIC_STAGES],
        !angles.ready, "input accepted while the CORDIC chain is full and blocked")

    // Presented entries r_xx and r_zz stay within plus or minus one.
    `E2R_ASSERT_NOW(a_entries_clamped, matrix.valid,
        matrix.r_xx <= ENT_HI && matrix.r_xx >= ENT_LO &&
        matrix.r_zz <= ENT_HI && matrix.r_zz >= ENT_LO,
        "matrix entry outside the saturation range")

endmodule

@@ tb/euler_to_rotation_matrix_tb.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for euler_to_rotation_matrix: directed and random angle items
// are run through a fixed-point CORDIC predictor and each matrix is compared entry by entry.
// Depends on e2r_pkg, e2r_angle_if, e2r_matrix_if and the block's RTL.
module euler_to_rotation_matrix_tb;
    import e2r_pkg::*;

    localparam int STAGES       = 14;
    localparam int ANG_W        = 16;
    localparam int AFRAC        = ANG_W - 3;
    localparam int SC_FRAC      = 20;
    localparam int LATENCY      = STAGES + 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int BLOCK_ITEMS  = 100;

    typedef logic signed [ANGLE_IN_W-1:0] angle_t;
    typedef logic [ENTRY_COUNT-1:0][ENTRY_W-1:0] rot_matrix_t;

    logic clk;
    logic rst_n;

    e2r_angle_if  angles();
    e2r_matrix_if matrix();

    euler_to_rotation_matrix #(
        .CORDIC_STAGES(STAGES),
        .ANGLE_WIDTH  (ANG_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .angles(angles),
        .matrix(matrix)
    );

    rot_matrix_t pending_matrices[$];
    int          errors    = 0;
    int          cycles    = 0;
    bit          src_quiet = 1'b0;
    bit          snk_quiet = 1'b0;

    function automatic longint atan_q30(int i);
        case (i)
            0:       return 64'sd843314856;
            1:       return 64'sd497837829;
            2:       return 64'sd263043836;
            3:       return 64'sd133525158;
            4:       return 64'sd67021686;
            5:       return 64'sd33543515;
            6:       return 64'sd16775850;
            7:       return 64'sd8388437;
            8:       return 64'sd4194282;
            9:       return 64'sd2097149;
            10:      return 64'sd1048575;
            11:      return 64'sd524287;
            12:      return 64'sd262143;
            13:      return 64'sd131071;
            14:      return 64'sd65535;
            15:      return 64'sd32767;
            16:      return 64'sd16383;
            17:      return 64'sd8191;
            18:      return 64'sd4095;
            default: return 64'sd2047;
        endcase
    endfunction

    // Half-up rounding; the arithmetic shift gives floor for negative values.
    function automatic longint shift_round(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void cordic_sin_cos(input angle_t a, output longint s, output longint c);
        longint ang;
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint half_pi;
        longint full_pi;
        bit     flip;
        int     n;
        int     i;
        if (AFRAC >= 12)
            ang = longint'(a) <<< (AFRAC - 12);
        else
            ang = longint'(a) >>> (12 - AFRAC);
        half_pi = shift_round(64'sd1686629713, 30 - AFRAC);
        full_pi = shift_round(64'sd3373259426, 30 - AFRAC);
        flip = 1'b0;
        // Fold the outer half circle onto the inner one and negate both outputs.
        if (ang > half_pi)
        begin
            ang  = ang - full_pi;
            flip = 1'b1;
        end
        else if (ang < -half_pi)
        begin
            ang  = ang + full_pi;
            flip = 1'b1;
        end
        px = 64'sd652032874;
        py = 0;
        n  = (STAGES < 20) ? STAGES : 20;
        for (i = 0; i < n; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (ang >= 0)
            begin
                px  = px - dx;
                py  = py + dy;
                ang = ang - shift_round(atan_q30(i), 30 - AFRAC);
            end
            else
            begin
                px  = px + dx;
                py  = py - dy;
                ang = ang + shift_round(atan_q30(i), 30 - AFRAC);
            end
        end
        px = shift_round(px, 30 - SC_FRAC);
        py = shift_round(py, 30 - SC_FRAC);
        if (flip)
        begin
            px = -px;
            py = -py;
        end
        s = py;
        c = px;
    endfunction

    function automatic logic [ENTRY_W-1:0] to_q14(longint q60);
        longint v;
        v = shift_round(q60, 46);
        if (v > ONE_Q14)
            v = ONE_Q14;
        if (v < -ONE_Q14)
            v = -ONE_Q14;
        return v[ENTRY_W-1:0];
    endfunction

    function automatic rot_matrix_t rotation_of(angle_t ax, angle_t ay, angle_t az);
        longint      sx;
        longint      cx;
        longint      sy;
        longint      cy;
        longint      sz;
        longint      cz;
        longint      up;
        rot_matrix_t m;
        up = 64'sd1 <<< SC_FRAC;
        cordic_sin_cos(ax, sx, cx);
        cordic_sin_cos(ay, sy, cy);
        cordic_sin_cos(az, sz, cz);
        m[E_XX] = to_q14(cy * cz * up);
        m[E_XY] = to_q14(cz * sx * sy - cx * sz * up);
        m[E_XZ] = to_q14(sx * sz * up + cx * cz * sy);
        m[E_YX] = to_q14(cy * sz * up);
        m[E_YY] = to_q14(sx * sy * sz + cx * cz * up);
        m[E_YZ] = to_q14(cx * sy * sz - cz * sx * up);
        m[E_ZX] = to_q14(-sy * up * up);
        m[E_ZY] = to_q14(cy * sx * up);
        m[E_ZZ] = to_q14(cx * cy * up);
        return m;
    endfunction

    function automatic string entry_label(int i);
        case (i)
            E_XX:    return "r_xx";
            E_XY:    return "r_xy";
            E_XZ:    return "r_xz";
            E_YX:    return "r_yx";
            E_YY:    return "r_yy";
            E_YZ:    return "r_yz";
            E_ZX:    return "r_zx";
            E_ZY:    return "r_zy";
            default: return "r_zz";
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic angle_t random_angle();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 70)
            return angle_t'(int'($urandom_range(0, 25736)) - 12868);
        if (r < 80)
            return angle_t'($urandom);
        if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       base = 6434;
                1:       base = -6434;
                2:       base = 12868;
                default: base = -12868;
            endcase
            return angle_t'(base + int'($urandom_range(0, 8)) - 4);
        end
        return angle_t'(int'($urandom_range(0, 128)) - 64);
    endfunction

    // Called at a rising edge; returns at the rising edge where the item was taken.
    task automatic send_angles(input angle_t ax, input angle_t ay, input angle_t az);
        int gap;
        bit taken;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            angles.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        angles.valid   <= 1'b1;
        angles.angle_x <= ax;
        angles.angle_y <= ay;
        angles.angle_z <= az;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = angles.ready;
            @(posedge clk);
        end
        pending_matrices.push_back(rotation_of(ax, ay, az));
    endtask

    task automatic hold_angles();
        angles.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_matrices.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_angles(0, 0, 0);
        send_angles(12868, 12868, 12868);
        send_angles(-12868, -12868, -12868);
        send_angles(12868, -12868, 0);
        send_angles(16383, -16384, 16383);
        send_angles(-16384, 16383, -16384);
        // Pitch at plus or minus a quarter turn drives r_zx against the clamp.
        send_angles(0, 6434, 0);
        send_angles(0, -6434, 0);
        send_angles(3217, 3217, 3217);
    endtask

    // Angles on both sides of the quarter-turn folds.
    task automatic test_quadrant_folds();
        send_angles(6434, 6435, -6435);
        send_angles(6435, -6434, 6434);
        send_angles(-6435, 6433, 6436);
        send_angles(-6434, -6435, 6435);
        send_angles(6436, 12867, -6436);
        send_angles(8192, -8192, 10000);
        send_angles(-10000, 4096, -4096);
        send_angles(12000, -3000, 7000);
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 20; i++)
            send_angles(random_angle(), random_angle(), random_angle());
        hold_angles();
        wait_drained();
        for (i = 0; i < 10; i++)
            send_angles(random_angle(), random_angle(), random_angle());
    endtask

    task automatic test_random();
        int blk;
        int i;
        for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++)
        begin
            src_quiet = (blk % 4 == 1) || (blk % 4 == 3);
            snk_quiet = (blk % 4 == 2) || (blk % 4 == 3);
            for (i = 0; i < BLOCK_ITEMS; i++)
                send_angles(random_angle(), random_angle(), random_angle());
        end
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
    endtask

    task automatic check_matrix();
        rot_matrix_t got;
        rot_matrix_t want;
        int          i;
        got[E_XX] = matrix.r_xx;
        got[E_XY] = matrix.r_xy;
        got[E_XZ] = matrix.r_xz;
        got[E_YX] = matrix.r_yx;
        got[E_YY] = matrix.r_yy;
        got[E_YZ] = matrix.r_yz;
        got[E_ZX] = matrix.r_zx;
        got[E_ZY] = matrix.r_zy;
        got[E_ZZ] = matrix.r_zz;
        if (pending_matrices.size() == 0)
        begin
            errors++;
            $display("%0t: matrix item with no angle item outstanding", $time);
        end
        else
        begin
            want = pending_matrices.pop_front();
            for (i = 0; i < ENTRY_COUNT; i++)
            begin
                if (got[i] !== want[i])
                begin
                    errors++;
                    $display("%0t: %s expected %0d actual %0d", $time, entry_label(i),
                             $signed(want[i]), $signed(got[i]));
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Outputs are sampled on the falling edge, where they are stable for the coming handshake.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && matrix.valid && matrix.ready)
                check_matrix();
        end
    end

    initial
    begin
        int stall;
        matrix.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = snk_quiet ? 0 : pick_gap();
            if (stall > 0)
            begin
                matrix.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            matrix.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        angles.valid   <= 1'b0;
        angles.angle_x <= '0;
        angles.angle_y <= '0;
        angles.angle_z <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_quadrant_folds();
        test_drain_pause();
        test_random();
        hold_angles();
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/e2r_pkg.sv
sv/e2r_angle_if.sv
sv/e2r_matrix_if.sv
sv/e2r_cordic_cell.sv
sv/e2r_matrix.sv
sv/euler_to_rotation_matrix.sv
tb/euler_to_rotation_matrix_tb.sv
